// File: hdl/kads_pkg.sv
package kads_pkg;

    localparam int MODE_W     = 3;
    localparam int SECS_W     = 16;
    localparam int MAXS_W     = 8;
    localparam int IVL_W      = 20;
    localparam int GRACE_W    = 8;
    localparam int LEVEL_W    = 5;
    localparam int MSPS_W     = 10;
    localparam int EXT_W      = MAXS_W + MSPS_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = IVL_W;

    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_mode MODE_INIT      = 3'd0;
    localparam t_mode MODE_TICK      = 3'd1;
    localparam t_mode MODE_KEEPALIVE = 3'd2;
    localparam t_mode MODE_START     = 3'd3;
    localparam t_mode MODE_STOP      = 3'd4;

    localparam t_cfg_idx CFG_MAX_KEEPALIVE = 2'd0;
    localparam t_cfg_idx CFG_BEAT_INTERVAL = 2'd1;
    localparam t_cfg_idx CFG_GRACE_BEATS   = 2'd2;

    localparam logic [MAXS_W-1:0]  RST_MAX_KEEPALIVE = 8'd45;
    localparam logic [IVL_W-1:0]   RST_BEAT_INTERVAL = 20'd10000;
    localparam logic [GRACE_W-1:0] RST_GRACE_BEATS   = 8'd3;

    localparam logic [MSPS_W-1:0]  MS_PER_SECOND = 10'd1000;
    localparam logic [LEVEL_W-1:0] LEVEL_BRIGHT  = 5'd30;
    localparam logic [LEVEL_W-1:0] LEVEL_DIM     = 5'd15;
    localparam logic [LEVEL_W-1:0] LEVEL_OFF     = 5'd0;

    typedef struct packed {
        logic  valid;
        t_mode mode;
        logic  secs_nz;
    } t_prep_ctl;

endpackage

// File: hdl/kads_if.sv
interface kads_item_if #(parameter int TIME_BITS = 48) ();
    logic                         valid;
    logic                         ready;
    logic [kads_pkg::MODE_W-1:0]  mode;
    logic [TIME_BITS-1:0]         now_ms;
    logic [kads_pkg::SECS_W-1:0]  seconds;

    modport source (output valid, output mode, output now_ms, output seconds, input ready);
    modport sink   (input valid, input mode, input now_ms, input seconds, output ready);
endinterface

interface kads_result_if ();
    logic                          valid;
    logic                          ready;
    logic                          kick;
    logic                          expire;
    logic                          led_set;
    logic [kads_pkg::LEVEL_W-1:0]  led_level;

    modport source (output valid, output kick, output expire, output led_set,
                    output led_level, input ready);
    modport sink   (input valid, input kick, input expire, input led_set,
                    input led_level, output ready);
endinterface

interface kads_cfg_if ();
    logic                             valid;
    logic                             ready;
    logic [kads_pkg::CFG_IDX_W-1:0]   index;
    logic [kads_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/kads_prep.sv
module kads_prep #(
    parameter int TIME_BITS = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    kads_item_if.sink                     i_item,
    input  logic                          i_advance,
    input  logic [kads_pkg::MAXS_W-1:0]   i_max_secs,
    output kads_pkg::t_prep_ctl           o_ctl,
    output logic [TIME_BITS-1:0]          o_now,
    output logic [TIME_BITS-1:0]          o_target
);

    kads_pkg::t_prep_ctl           r_ctl;
    logic [TIME_BITS-1:0]          r_now;
    logic [TIME_BITS-1:0]          r_target;

    logic [kads_pkg::MAXS_W-1:0]   capped;
    logic [kads_pkg::EXT_W-1:0]    ext;
    logic [TIME_BITS:0]            sum;
    logic [TIME_BITS-1:0]          n_target;
    logic                          take;

    assign i_item.ready = !r_ctl.valid || i_advance;
    assign take         = i_item.valid && i_item.ready;

    // cap the request, scale to ms, saturate the new deadline at the top of the time range
    always_comb begin
        if (i_item.seconds > kads_pkg::SECS_W'(i_max_secs)) begin
            capped = i_max_secs;
        end else begin
            capped = i_item.seconds[kads_pkg::MAXS_W-1:0];
        end
        ext = kads_pkg::EXT_W'(capped) * kads_pkg::EXT_W'(kads_pkg::MS_PER_SECOND);
        sum = {1'b0, i_item.now_ms} + (TIME_BITS+1)'(ext);
        if (sum[TIME_BITS]) begin
            n_target = '1;
        end else begin
            n_target = sum[TIME_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (take) begin
            r_ctl.valid   <= 1'b1;
            r_ctl.mode    <= i_item.mode;
            r_ctl.secs_nz <= (i_item.seconds != '0);
        end else if (i_advance) begin
            r_ctl.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_now    <= i_item.now_ms;
            r_target <= n_target;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_now    = r_now;
    assign o_target = r_target;

endmodule

// File: hdl/keepalive_deadline_supervisor_unit.sv
// Keep-alive deadline supervisor.
// i_item carries one event (init, tick, keepalive, start, stop) with the current
// millisecond time and a requested keep-alive in seconds. o_result returns exactly
// one result per event: kick, expire, led_set and led_level for the watchdog side.
// i_cfg writes max_keepalive_seconds (index 0), beat_interval_ms (index 1) and
// grace_beats (index 2); it is always ready. The user must write it only while
// idle; the block itself does not enforce this. An i_item transfer goes to the
// input register, where the capped extension and saturated target are formed,
// then to the supervisor stage, which updates the state and loads the result
// register. Throughput is one event per cycle while o_result is not stalled.
// When o_result stalls the result register holds, the input register keeps the
// next event, and i_item.ready drops only once both are full.
// Reset clears the supervisor state (disabled, no grace beats, deadline zero,
// LED phase zero), empties both registers and restores the configuration defaults.
module keepalive_deadline_supervisor_unit #(
    parameter int TIME_BITS = 48
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    kads_item_if.sink    i_item,
    kads_result_if.source o_result,
    kads_cfg_if.sink     i_cfg
);

    logic [kads_pkg::MAXS_W-1:0]   r_max_secs;
    logic [kads_pkg::IVL_W-1:0]    r_interval;
    logic [kads_pkg::GRACE_W-1:0]  r_grace_beats;

    logic                          r_enabled,  n_enabled;
    logic [kads_pkg::GRACE_W-1:0]  r_grace,    n_grace;
    logic [TIME_BITS-1:0]          r_deadline, n_deadline;
    logic                          r_phase,    n_phase;

    logic                          r_out_valid;
    logic                          r_kick,     n_kick;
    logic                          r_expire,   n_expire;
    logic                          r_led_set,  n_led_set;
    logic [kads_pkg::LEVEL_W-1:0]  r_led_level, n_led_level;

    kads_pkg::t_prep_ctl           ctl;
    logic [TIME_BITS-1:0]          now;
    logic [TIME_BITS-1:0]          target;
    logic [TIME_BITS-1:0]          ahead;
    logic                          early;
    logic                          advance;
    logic                          fire;

    assign advance = !r_out_valid || o_result.ready;
    assign fire    = advance && ctl.valid;

    kads_prep #(
        .TIME_BITS (TIME_BITS)
    ) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_advance  (advance),
        .i_max_secs (r_max_secs),
        .o_ctl      (ctl),
        .o_now      (now),
        .o_target   (target)
    );

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_secs    <= kads_pkg::RST_MAX_KEEPALIVE;
            r_interval    <= kads_pkg::RST_BEAT_INTERVAL;
            r_grace_beats <= kads_pkg::RST_GRACE_BEATS;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                kads_pkg::CFG_MAX_KEEPALIVE: r_max_secs    <= i_cfg.data[kads_pkg::MAXS_W-1:0];
                kads_pkg::CFG_BEAT_INTERVAL: r_interval    <= i_cfg.data;
                kads_pkg::CFG_GRACE_BEATS:   r_grace_beats <= i_cfg.data[kads_pkg::GRACE_W-1:0];
                default: ;
            endcase
        end
    end

    // distance to the deadline wraps when already passed, so no early kick then
    assign ahead = r_deadline - now;
    assign early = ahead < TIME_BITS'(r_interval);

    always_comb begin
        n_enabled   = r_enabled;
        n_grace     = r_grace;
        n_deadline  = r_deadline;
        n_phase     = r_phase;
        n_kick      = 1'b0;
        n_expire    = 1'b0;
        n_led_set   = 1'b0;
        n_led_level = kads_pkg::LEVEL_OFF;
        case (ctl.mode)
            kads_pkg::MODE_INIT: begin
                n_grace   = r_grace_beats;
                n_enabled = 1'b1;
            end
            kads_pkg::MODE_TICK: begin
                n_phase = ~r_phase;
                if (r_enabled) begin
                    if (r_grace != '0) begin
                        n_grace = r_grace - 1'b1;
                        n_kick  = 1'b1;
                    end else if (now > r_deadline) begin
                        n_expire = 1'b1;
                    end else begin
                        n_kick      = 1'b1;
                        n_led_set   = 1'b1;
                        n_led_level = n_phase ? kads_pkg::LEVEL_DIM : kads_pkg::LEVEL_BRIGHT;
                    end
                end
            end
            kads_pkg::MODE_KEEPALIVE, kads_pkg::MODE_START: begin
                if (ctl.secs_nz) begin
                    if (ctl.mode == kads_pkg::MODE_START) begin
                        n_enabled = 1'b1;
                    end
                    n_kick = early;
                    // push the deadline forward, never back
                    if (target > r_deadline) begin
                        n_deadline = target;
                    end
                end
            end
            kads_pkg::MODE_STOP: begin
                n_enabled = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_grace     <= '0;
            r_deadline  <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_enabled   <= n_enabled;
                r_grace     <= n_grace;
                r_deadline  <= n_deadline;
                r_phase     <= n_phase;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_kick      <= n_kick;
            r_expire    <= n_expire;
            r_led_set   <= n_led_set;
            r_led_level <= n_led_level;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.kick      = r_kick;
    assign o_result.expire    = r_expire;
    assign o_result.led_set   = r_led_set;
    assign o_result.led_level = r_led_level;

endmodule

// File: hdl/kads_checker.sv
module kads_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_kick,
    input  logic                          i_expire,
    input  logic                          i_led_set,
    input  logic [kads_pkg::LEVEL_W-1:0]  i_led_level
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kick) && $stable(i_expire)
            && $stable(i_led_set) && $stable(i_led_level))
        else $error("result changed while stalled");

    a_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_led_set |-> i_kick && !i_expire
            && (i_led_level == kads_pkg::LEVEL_BRIGHT || i_led_level == kads_pkg::LEVEL_DIM))
        else $error("LED drive without a plain kick");

    a_led_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_led_set |-> i_led_level == kads_pkg::LEVEL_OFF)
        else $error("LED level without LED drive");

    a_expire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_expire |-> !i_kick)
        else $error("kick and expire together");

    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind keepalive_deadline_supervisor_unit kads_checker u_kads_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_kick      (o_result.kick),
    .i_expire    (o_result.expire),
    .i_led_set   (o_result.led_set),
    .i_led_level (o_result.led_level)
);

// File: test/keepalive_deadline_supervisor_unit_tb.sv
module keepalive_deadline_supervisor_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB_TIME_BITS = 48;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 250;

    localparam logic [TB_TIME_BITS-1:0] TIME_MAX = '1;

    // Modes the block must ignore.
    localparam kads_pkg::t_mode MODE_RSVD_LO = 3'd5;
    localparam kads_pkg::t_mode MODE_RSVD_HI = 3'd7;

    typedef struct packed {
        logic                          kick;
        logic                          expire;
        logic                          led_set;
        logic [kads_pkg::LEVEL_W-1:0]  led_level;
    } t_outcome;

    typedef struct packed {
        kads_pkg::t_mode               mode;
        logic [TB_TIME_BITS-1:0]       now;
        logic [kads_pkg::SECS_W-1:0]   secs;
        logic                          typed;
        t_outcome                      want;
    } t_row;

    localparam t_outcome OUT_NONE   = '{1'b0, 1'b0, 1'b0, kads_pkg::LEVEL_OFF};
    localparam t_outcome OUT_KICK   = '{1'b1, 1'b0, 1'b0, kads_pkg::LEVEL_OFF};
    localparam t_outcome OUT_EXPIRE = '{1'b0, 1'b1, 1'b0, kads_pkg::LEVEL_OFF};
    localparam t_outcome OUT_BRIGHT = '{1'b1, 1'b0, 1'b1, kads_pkg::LEVEL_BRIGHT};
    localparam t_outcome OUT_DIM    = '{1'b1, 1'b0, 1'b1, kads_pkg::LEVEL_DIM};

    // Walked with the reset register values (45 s cap, 10000 ms interval, 3 grace beats).
    localparam t_row SCRIPT [25] = '{
        '{kads_pkg::MODE_TICK,      48'd0,              16'd0,    1'b1, OUT_NONE},
        '{kads_pkg::MODE_KEEPALIVE, 48'd0,              16'd0,    1'b1, OUT_NONE},
        '{kads_pkg::MODE_STOP,      48'd0,              16'd0,    1'b1, OUT_NONE},
        '{MODE_RSVD_LO,             TIME_MAX,           16'hffff, 1'b1, OUT_NONE},
        '{MODE_RSVD_HI,             TIME_MAX,           16'hffff, 1'b1, OUT_NONE},
        '{kads_pkg::MODE_INIT,      48'd100,            16'd0,    1'b1, OUT_NONE},
        '{kads_pkg::MODE_TICK,      48'd200,            16'd0,    1'b1, OUT_KICK},
        '{kads_pkg::MODE_TICK,      48'd200,            16'd0,    1'b1, OUT_KICK},
        '{kads_pkg::MODE_TICK,      48'd200,            16'd0,    1'b1, OUT_KICK},
        '{kads_pkg::MODE_TICK,      48'd300,            16'd0,    1'b1, OUT_EXPIRE},
        '{kads_pkg::MODE_KEEPALIVE, 48'd1000,           16'd5,    1'b1, OUT_NONE},
        '{kads_pkg::MODE_KEEPALIVE, 48'd2000,           16'd100,  1'b1, OUT_KICK},
        '{kads_pkg::MODE_TICK,      48'd3000,           16'd0,    1'b1, OUT_BRIGHT},
        '{kads_pkg::MODE_TICK,      48'd47000,          16'd0,    1'b1, OUT_DIM},
        '{kads_pkg::MODE_KEEPALIVE, 48'd47000,          16'd1,    1'b0, OUT_NONE},
        '{kads_pkg::MODE_KEEPALIVE, 48'd3000,           16'd1,    1'b0, OUT_NONE},
        '{kads_pkg::MODE_TICK,      48'd48001,          16'd0,    1'b0, OUT_NONE},
        '{kads_pkg::MODE_STOP,      48'd48001,          16'd0,    1'b1, OUT_NONE},
        '{kads_pkg::MODE_TICK,      48'd49000,          16'd0,    1'b1, OUT_NONE},
        '{kads_pkg::MODE_START,     48'd50000,          16'd0,    1'b1, OUT_NONE},
        '{kads_pkg::MODE_TICK,      48'd50000,          16'd0,    1'b0, OUT_NONE},
        '{kads_pkg::MODE_START,     48'd50000,          16'd10,   1'b0, OUT_NONE},
        '{kads_pkg::MODE_TICK,      48'd55000,          16'd0,    1'b0, OUT_NONE},
        '{kads_pkg::MODE_KEEPALIVE, TIME_MAX - 48'd999, 16'd45,   1'b0, OUT_NONE},
        '{kads_pkg::MODE_TICK,      TIME_MAX,           16'd0,    1'b0, OUT_NONE}
    };

    logic i_clk;
    logic i_rst_n;

    kads_item_if #(.TIME_BITS(TB_TIME_BITS)) item_if ();
    kads_result_if                           res_if ();
    kads_cfg_if                              cfg_if ();

    keepalive_deadline_supervisor_unit #(.TIME_BITS(TB_TIME_BITS)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    // Supervisor mirror: registers and state.
    logic [kads_pkg::MAXS_W-1:0]   cfg_max_secs;
    logic [kads_pkg::IVL_W-1:0]    cfg_interval;
    logic [kads_pkg::GRACE_W-1:0]  cfg_grace;
    logic                          sup_enabled;
    logic [kads_pkg::GRACE_W-1:0]  grace_left;
    logic [TB_TIME_BITS-1:0]       deadline;
    logic                          beat_phase;

    t_outcome expected_outcomes [$];
    int       mismatches  = 0;
    int       cycle_count = 0;
    int       stall_left  = 0;
    bit       idle_on     = 1'b1;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("keepalive_deadline_supervisor_unit_tb NOT OK");
            $finish;
        end
    end

    function automatic logic extend_deadline(input logic [TB_TIME_BITS-1:0] now,
                                             input logic [kads_pkg::SECS_W-1:0] secs);
        logic [kads_pkg::SECS_W-1:0]  capped;
        logic [kads_pkg::EXT_W-1:0]   ext_ms;
        logic [TB_TIME_BITS:0]        sum;
        logic [TB_TIME_BITS-1:0]      target;
        logic [TB_TIME_BITS-1:0]      gap;
        logic                         early;
        capped = (secs > kads_pkg::SECS_W'(cfg_max_secs)) ?
                 kads_pkg::SECS_W'(cfg_max_secs) : secs;
        // Distance wraps when the deadline is already behind now.
        gap    = deadline - now;
        early  = gap < TB_TIME_BITS'(cfg_interval);
        ext_ms = kads_pkg::EXT_W'(capped) * kads_pkg::EXT_W'(kads_pkg::MS_PER_SECOND);
        sum    = {1'b0, now} + (TB_TIME_BITS+1)'(ext_ms);
        target = sum[TB_TIME_BITS] ? TIME_MAX : sum[TB_TIME_BITS-1:0];
        if (target > deadline)
            deadline = target;
        return early;
    endfunction

    function automatic t_outcome supervise_event(input kads_pkg::t_mode mode,
                                                 input logic [TB_TIME_BITS-1:0] now,
                                                 input logic [kads_pkg::SECS_W-1:0] secs);
        t_outcome res;
        res = OUT_NONE;
        case (mode)
            kads_pkg::MODE_INIT: begin
                grace_left  = cfg_grace;
                sup_enabled = 1'b1;
            end
            kads_pkg::MODE_TICK: begin
                beat_phase = ~beat_phase;
                if (sup_enabled) begin
                    if (grace_left != 0) begin
                        grace_left = grace_left - 1'b1;
                        res.kick   = 1'b1;
                    end else if (now > deadline) begin
                        res.expire = 1'b1;
                    end else begin
                        res.kick      = 1'b1;
                        res.led_set   = 1'b1;
                        res.led_level = beat_phase ? kads_pkg::LEVEL_DIM
                                                   : kads_pkg::LEVEL_BRIGHT;
                    end
                end
            end
            kads_pkg::MODE_KEEPALIVE: begin
                if (secs != 0)
                    res.kick = extend_deadline(now, secs);
            end
            kads_pkg::MODE_START: begin
                if (secs != 0) begin
                    sup_enabled = 1'b1;
                    res.kick    = extend_deadline(now, secs);
                end
            end
            kads_pkg::MODE_STOP: begin
                sup_enabled = 1'b0;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_event(input kads_pkg::t_mode m, input logic [TB_TIME_BITS-1:0] now,
                              input logic [kads_pkg::SECS_W-1:0] secs, input logic typed,
                              input t_outcome want);
        t_outcome got;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        item_if.valid   <= 1'b1;
        item_if.mode    <= m;
        item_if.now_ms  <= now;
        item_if.seconds <= secs;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        got = supervise_event(m, now, secs);
        expected_outcomes.push_back(typed ? want : got);
    endtask

    // Drop valid and hold until every pending result has been seen.
    task automatic settle();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [kads_pkg::MAXS_W-1:0] maxs,
                                input logic [kads_pkg::IVL_W-1:0] ivl,
                                input logic [kads_pkg::GRACE_W-1:0] grace);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= kads_pkg::CFG_MAX_KEEPALIVE;
        cfg_if.data  <= kads_pkg::CFG_DATA_W'(maxs);
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_max_secs = maxs;
        cfg_if.index <= kads_pkg::CFG_BEAT_INTERVAL;
        cfg_if.data  <= kads_pkg::CFG_DATA_W'(ivl);
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_interval = ivl;
        cfg_if.index <= kads_pkg::CFG_GRACE_BEATS;
        cfg_if.data  <= kads_pkg::CFG_DATA_W'(grace);
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_grace = grace;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_phase(input int count);
        logic [TB_TIME_BITS-1:0]      clk_ms;
        logic [kads_pkg::SECS_W-1:0]  secs;
        int                           pick;
        int                           span;
        case ($urandom_range(0, 3))
            0:       clk_ms = '0;
            1:       clk_ms = TIME_MAX - 48'd400000;
            default: clk_ms = TB_TIME_BITS'({$urandom(), $urandom()});
        endcase
        send_event(kads_pkg::MODE_INIT, clk_ms, '0, 1'b0, OUT_NONE);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0:       secs = '0;
                1:       secs = kads_pkg::SECS_W'($urandom());
                default: secs = kads_pkg::SECS_W'($urandom_range(1, int'(cfg_max_secs) + 8));
            endcase
            // Advance time on the scale of one keep-alive extension.
            span = int'(cfg_max_secs) * 600 + 50;
            if ($urandom_range(0, 9) == 0)
                span = span * 4 + 20000;
            if ($urandom_range(0, 3) != 0)
                clk_ms = clk_ms + TB_TIME_BITS'($urandom_range(0, span));
            if (pick < 40)
                send_event(kads_pkg::MODE_TICK, clk_ms, secs, 1'b0, OUT_NONE);
            else if (pick < 75)
                send_event(kads_pkg::MODE_KEEPALIVE, clk_ms, secs, 1'b0, OUT_NONE);
            else if (pick < 80)
                send_event(kads_pkg::MODE_START, clk_ms, secs, 1'b0, OUT_NONE);
            else if (pick < 83)
                send_event(kads_pkg::MODE_STOP, clk_ms, secs, 1'b0, OUT_NONE);
            else if (pick < 86)
                send_event(kads_pkg::MODE_INIT, clk_ms, secs, 1'b0, OUT_NONE);
            else if (pick < 90)
                send_event(kads_pkg::t_mode'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI)),
                           clk_ms, secs, 1'b0, OUT_NONE);
            else
                send_event(kads_pkg::t_mode'($urandom_range(kads_pkg::MODE_INIT,
                                                            MODE_RSVD_HI)),
                           TB_TIME_BITS'({$urandom(), $urandom()}),
                           kads_pkg::SECS_W'($urandom()), 1'b0, OUT_NONE);
            if ($urandom_range(0, 199) == 0)
                settle();
        end
    endtask

    // Result side backpressure in bursts.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            res_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left   <= $urandom_range(0, 6);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_outcomes.size() == 0) begin
                $error("result transfer with no pending expectation");
                mismatches++;
            end else begin
                want = expected_outcomes.pop_front();
                check_field("kick", want.kick, res_if.kick);
                check_field("expire", want.expire, res_if.expire);
                check_field("led_set", want.led_set, res_if.led_set);
                check_field("led_level", want.led_level, res_if.led_level);
            end
        end
    end

    initial begin
        logic [kads_pkg::MAXS_W-1:0]   maxs;
        logic [kads_pkg::IVL_W-1:0]    ivl;
        logic [kads_pkg::GRACE_W-1:0]  grace;
        i_rst_n         <= 1'b0;
        item_if.valid   <= 1'b0;
        item_if.mode    <= kads_pkg::MODE_INIT;
        item_if.now_ms  <= '0;
        item_if.seconds <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= kads_pkg::CFG_MAX_KEEPALIVE;
        cfg_if.data     <= '0;
        cfg_max_secs = kads_pkg::RST_MAX_KEEPALIVE;
        cfg_interval = kads_pkg::RST_BEAT_INTERVAL;
        cfg_grace    = kads_pkg::RST_GRACE_BEATS;
        sup_enabled  = 1'b0;
        grace_left   = '0;
        deadline     = '0;
        beat_phase   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (SCRIPT[r])
            send_event(SCRIPT[r].mode, SCRIPT[r].now, SCRIPT[r].secs, SCRIPT[r].typed,
                       SCRIPT[r].want);
        settle();

        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin maxs = kads_pkg::RST_MAX_KEEPALIVE; ivl = kads_pkg::RST_BEAT_INTERVAL;
                         grace = kads_pkg::RST_GRACE_BEATS; end
                1: begin maxs = 8'd1;   ivl = 20'd1;       grace = 8'd0;   end
                2: begin maxs = 8'd255; ivl = 20'd1000000; grace = 8'd255; end
                3: begin maxs = 8'd0;   ivl = 20'd0;       grace = 8'd1;   end
                4: begin maxs = 8'd255; ivl = '1;          grace = 8'd0;   end
                default: begin
                    maxs  = kads_pkg::MAXS_W'($urandom_range(1, 255));
                    ivl   = kads_pkg::IVL_W'($urandom_range(1, 1000000));
                    grace = kads_pkg::GRACE_W'($urandom_range(0, 8));
                end
            endcase
            // Run the final stretch at full rate on both sides.
            if (p == 6)
                idle_on = 1'b0;
            program_regs(maxs, ivl, grace);
            run_phase(PHASE_ITEMS);
            settle();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("keepalive_deadline_supervisor_unit_tb OK");
        else
            $display("keepalive_deadline_supervisor_unit_tb NOT OK");
        $finish;
    end

endmodule
